### src/fpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_pkg
// shared types and constants of the front panel sense monitor
// ----------------------------------------------------------------------------
package fpsm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TICK_W      = 32;
    localparam int TPS_W       = 16;
    localparam int AVGN_W      = 10;
    localparam int TEMP_W      = 20;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    // temperature conversion: t = offset - ((raw * slope) >> 8)
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 20'sd111931;
    localparam logic [14:0]              TEMP_SLOPE  = 15'd30680;

    // configuration reset values
    localparam logic [SAMPLE_BITS-1:0] PWR_THR_RST = 12'd2000;
    localparam logic [SAMPLE_BITS-1:0] HDD_THR_RST = 12'd2000;
    localparam logic [TPS_W-1:0]       TPS_RST     = 16'd1000;
    localparam logic [AVGN_W-1:0]      AVGN_RST    = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER_THR = 2'd0,
        CFG_HDD_THR   = 2'd1,
        CFG_TICKS_SEC = 2'd2,
        CFG_AVG_COUNT = 2'd3
    } t_fpsm_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] power_sense;
        logic [SAMPLE_BITS-1:0] disk_sense;
        logic [SAMPLE_BITS-1:0] temp_raw;
        logic [TICK_W-1:0]      tick_now;
    } t_fpsm_in;

    typedef struct packed {
        logic                     supply_on;
        logic                     disk_on;
        logic signed [TEMP_W-1:0] temp_avg;
        logic [TICK_W-1:0]        uptime_seconds;
    } t_fpsm_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic conv;
        logic acc;
        logic up_start;
        logic up_store;
        logic avg_start;
        logic avg_store;
        logic emit;
    } t_fpsm_cmd;

    // datapath to controller status
    typedef struct packed {
        logic up_need;
        logic avg_need;
    } t_fpsm_stat;

endpackage

### src/fpsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_div
// shared restoring divider, 32 by 16 bit unsigned, one quotient bit a cycle
// ----------------------------------------------------------------------------
module fpsm_div
    import fpsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [TPS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [TICK_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [TPS_W-1:0]  r_rem;
    logic [TPS_W-1:0]  r_dvs;
    logic [TICK_W-1:0] r_quo;

    logic [TPS_W:0]    w_trial;
    logic [TPS_W+1:0]  w_diff;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_quo[TICK_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[TPS_W+1]) begin
                r_rem <= w_diff[TPS_W-1:0];
                r_quo <= {r_quo[TICK_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[TPS_W-1:0];
                r_quo <= {r_quo[TICK_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/fpsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_ctrl
// sequencer for one polling round and the output handshake
// ----------------------------------------------------------------------------
module fpsm_ctrl
    import fpsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_fpsm_stat i_stat,
    input  logic       i_div_done,
    output t_fpsm_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_ACC,
        S_UP_CHK,
        S_UP_WAIT,
        S_AVG_CHK,
        S_AVG_WAIT,
        S_EMIT
    } t_state;

    t_state    r_state;
    logic      r_in_ready;
    logic      r_out_valid;
    logic      r_fin;
    t_fpsm_cmd r_cmd;
    logic      w_load;

    assign w_load = i_in_valid && r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
            r_cmd       <= '0;
        end else begin
            r_cmd <= '0;
            r_fin <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // result register loads during the finish cycle
            if (r_fin) begin
                r_out_valid <= 1'b1;
                r_in_ready  <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_in_ready <= 1'b0;
                        r_cmd.conv <= 1'b1;
                        r_state    <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_cmd.acc <= 1'b1;
                    r_state   <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_UP_CHK;
                end
                S_UP_CHK: begin
                    if (i_stat.up_need) begin
                        r_cmd.up_start <= 1'b1;
                        r_state        <= S_UP_WAIT;
                    end else begin
                        r_state <= S_AVG_CHK;
                    end
                end
                S_UP_WAIT: begin
                    if (i_div_done) begin
                        r_cmd.up_store <= 1'b1;
                        r_state        <= S_AVG_CHK;
                    end
                end
                S_AVG_CHK: begin
                    if (i_stat.avg_need) begin
                        r_cmd.avg_start <= 1'b1;
                        r_state         <= S_AVG_WAIT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_AVG_WAIT: begin
                    if (i_div_done) begin
                        r_cmd.avg_store <= 1'b1;
                        r_state         <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_cmd.emit <= 1'b1;
                        r_fin      <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd      = r_cmd;
        o_cmd.load = w_load;
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### src/fpsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsm_dp
// datapath: configuration, power and uptime state, temperature averaging
// ----------------------------------------------------------------------------
module fpsm_dp
    import fpsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_fpsm_in              i_in_data,
    input  t_fpsm_cmd             i_cmd,
    output t_fpsm_stat            o_stat,
    output logic [TICK_W-1:0]     o_div_dividend,
    output logic [TPS_W-1:0]      o_div_divisor,
    input  logic [TICK_W-1:0]     i_div_quotient,
    output t_fpsm_out             o_out_data
);

    localparam int PROD_W = SAMPLE_BITS + 15;
    localparam int SUM_W  = 31;
    localparam logic signed [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [TEMP_W-1:0] AVG_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] AVG_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    // configuration
    logic [SAMPLE_BITS-1:0] r_pwr_thr;
    logic [SAMPLE_BITS-1:0] r_hdd_thr;
    logic [TPS_W-1:0]       r_tps;
    logic [AVGN_W-1:0]      r_avgn;

    // round state
    t_fpsm_in               r_in;
    logic                   r_powered;
    logic [TICK_W-1:0]      r_start;
    logic [AVGN_W-1:0]      r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [TEMP_W-1:0] r_latched;

    // per round working registers
    logic                     r_disk;
    logic                     r_up_need;
    logic                     r_avg_need;
    logic [TICK_W-1:0]        r_elapsed;
    logic [TICK_W-1:0]        r_uptime;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [SUM_W-1:0]  r_hold;
    logic [AVGN_W:0]          r_n;
    t_fpsm_out                r_out;

    logic [PROD_W-1:0]        w_prod;
    logic signed [TEMP_W-1:0] w_temp;
    logic                     w_pwr_now;
    logic signed [SUM_W:0]    w_sum_add;
    logic signed [SUM_W-1:0]  w_sum_sat;
    logic [AVGN_W-1:0]        w_cnt_next;
    logic                     w_latch;
    logic [SUM_W-1:0]         w_hold_mag;
    logic                     w_neg;
    logic signed [TEMP_W-1:0] w_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr_thr <= PWR_THR_RST;
            r_hdd_thr <= HDD_THR_RST;
            r_tps     <= TPS_RST;
            r_avgn    <= AVGN_RST;
        end else if (i_cfg_we) begin
            case (t_fpsm_cfg_idx'(i_cfg_index))
                CFG_POWER_THR: r_pwr_thr <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_HDD_THR:   r_hdd_thr <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_TICKS_SEC: r_tps     <= i_cfg_data[TPS_W-1:0];
                CFG_AVG_COUNT: r_avgn    <= i_cfg_data[AVGN_W-1:0];
                default: ;
            endcase
        end
    end

    // temperature conversion
    assign w_prod    = PROD_W'(r_in.temp_raw) * PROD_W'(TEMP_SLOPE);
    assign w_temp    = TEMP_OFFSET - $signed({1'b0, w_prod[PROD_W-1:8]});
    assign w_pwr_now = (r_in.power_sense >= r_pwr_thr);

    // saturating accumulate and latch decision
    assign w_sum_add  = {r_sum[SUM_W-1], r_sum}
                      + {{(SUM_W+1-TEMP_W){r_temp[TEMP_W-1]}}, r_temp};
    assign w_sum_sat  = (w_sum_add[SUM_W] != w_sum_add[SUM_W-1])
                      ? (w_sum_add[SUM_W] ? SUM_MIN : SUM_MAX)
                      : w_sum_add[SUM_W-1:0];
    assign w_cnt_next = r_count + AVGN_W'(1);
    assign w_latch    = (w_cnt_next == '0) || (w_cnt_next >= r_avgn);

    // magnitude of the held sum for the unsigned divider
    assign w_neg      = r_hold[SUM_W-1];
    assign w_hold_mag = w_neg ? (-r_hold) : r_hold;

    // signed, saturated average from the quotient
    always_comb begin
        if (!w_neg) begin
            w_avg = (|i_div_quotient[TICK_W-1:TEMP_W-1]) ? AVG_MAX
                  : $signed(i_div_quotient[TEMP_W-1:0]);
        end else begin
            w_avg = (i_div_quotient > TICK_W'(32'd524288)) ? AVG_MIN
                  : -$signed(i_div_quotient[TEMP_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powered <= 1'b0;
            r_start   <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_latched <= '0;
        end else begin
            if (i_cmd.conv) begin
                r_powered <= w_pwr_now;
                if (w_pwr_now && !r_powered) begin
                    r_start <= r_in.tick_now;
                end
            end
            if (i_cmd.acc) begin
                if (w_latch) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= w_sum_sat;
                    r_count <= w_cnt_next;
                end
            end
            if (i_cmd.avg_store) begin
                r_latched <= w_avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.conv) begin
            r_temp    <= w_temp;
            r_disk    <= (r_in.disk_sense >= r_hdd_thr);
            // uptime on the rising edge is zero, no division needed
            r_up_need <= w_pwr_now && r_powered;
            r_elapsed <= r_in.tick_now - r_start;
            r_uptime  <= '0;
        end
        if (i_cmd.acc) begin
            r_avg_need <= w_latch;
            r_hold     <= w_sum_sat;
            r_n        <= (w_cnt_next == '0) ? {1'b1, {AVGN_W{1'b0}}}
                                             : {1'b0, w_cnt_next};
        end
        if (i_cmd.up_store) begin
            r_uptime <= i_div_quotient;
        end
        if (i_cmd.emit) begin
            r_out.supply_on      <= r_powered;
            r_out.disk_on        <= r_disk;
            r_out.temp_avg       <= r_latched;
            r_out.uptime_seconds <= r_uptime;
        end
    end

    // divider operands, captured by the divider on its start pulse
    always_comb begin
        if (i_cmd.avg_start) begin
            o_div_dividend = {1'b0, w_hold_mag};
            o_div_divisor  = TPS_W'(r_n);
        end else begin
            o_div_dividend = r_elapsed;
            o_div_divisor  = (r_tps == '0) ? TPS_W'(1) : r_tps;
        end
    end

    assign o_stat.up_need  = r_up_need;
    assign o_stat.avg_need = r_avg_need;
    assign o_out_data      = r_out;

endmodule

### src/front_panel_sense_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_panel_sense_monitor
// power, disk and temperature monitor for front panel sense samples
// ----------------------------------------------------------------------------
// usage
//  - input channel: one transfer per polling round, carrying the power, disk
//    and temperature samples and the free-running tick count
//  - output channel: exactly one result transfer per round, in order
//  - configuration: the user must write thresholds, ticks per second and
//    averaging length via the plain write port while the block is idle,
//    which the block itself does not enforce
//  - sequence: after the input transfer the round converts the samples,
//    accumulates, runs the uptime and then the average division on the
//    shared 32-step divider when each is due, then registers the result
//  - rounds: one round at a time; the next input is taken the cycle after
//    the previous result has been written to the output register
//  - uptime and average share the divider, so their divisions run in turn
//  - reset (synchronous, active low) restores the default configuration,
//    marks power off and clears the sum, count and latched average
//  - a stalled receiver holds the result in the output register; the
//    block still accepts and works on one further round meanwhile, and
//    waits to write it until the pending result has been taken
// ----------------------------------------------------------------------------
module front_panel_sense_monitor
    import fpsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // polling round input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_fpsm_in              i_in_data,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_fpsm_out             o_out_data
);

    t_fpsm_cmd         w_cmd;
    t_fpsm_stat        w_stat;
    logic              w_div_done;
    logic [TICK_W-1:0] w_div_dividend;
    logic [TPS_W-1:0]  w_div_divisor;
    logic [TICK_W-1:0] w_div_quotient;

    // sequencer: steps each round through convert, accumulate and divides
    fpsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .i_div_done  (w_div_done),
        .o_cmd       (w_cmd)
    );

    // datapath: configuration registers, round state and result register
    fpsm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_data      (i_in_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_quotient (w_div_quotient),
        .o_out_data     (o_out_data)
    );

    // shared divider for uptime seconds and the temperature average
    fpsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cmd.up_start || w_cmd.avg_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

endmodule
